// ----- rtl/lbgc_pkg.sv -----
// Shared constants, types and register indexes of the LED bar gradient chaser.
`timescale 1ns / 1ps

package lbgc_pkg;

    localparam int BAR_CELLS   = 9;
    localparam int IDX_W       = 4;
    localparam int COLOR_W     = 24;
    localparam int CH_W        = 8;
    localparam int STEPS_W     = 8;
    localparam int PERIOD_W    = 16;
    localparam int TICKS_W     = 17;
    localparam int TDATA_W     = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int DIV_CNT_W   = 4;
    localparam int NUM_DIV     = 6;
    localparam int DSEL_W      = 3;

    localparam logic [IDX_W-1:0]     LAST_CELL = IDX_W'(BAR_CELLS - 1);
    localparam logic [TICKS_W-1:0]   TICKS_MAX = {TICKS_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_ACCENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd2;

    localparam logic [COLOR_W-1:0]   ACCENT_RESET = 24'hFF0000;
    localparam logic [STEPS_W-1:0]   STEPS_RESET  = 8'd50;
    localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 16'd50;

    typedef enum logic {
        CMD_TICK,
        CMD_WRITE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [IDX_W-1:0]   idx;
        logic [COLOR_W-1:0] color;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DSTART,
        ST_DWAIT,
        ST_EMIT
    } t_back_state;

endpackage

// ----- rtl/led_bar_gradient_chaser.sv -----
// Top level of the LED bar gradient chaser.
`timescale 1ns / 1ps

// Requests are millisecond ticks (tuser low) or base color writes (tuser high) for
// one of the nine cells. Once the ticks since the last frame exceed frame_period,
// the block sends one frame of nine cell colors, cell 0 first, tlast on cell 8.
// A write updates the base color store in the frame engine. A tick that starts a frame
// runs six serial divisions through the shared restoring divider and then sends one
// cell per cycle while the output is not stalled. A four-entry queue keeps taking
// requests while a frame is being built, until it is full. The base color store resets
// to all cells off.

module led_bar_gradient_chaser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wen,
    input  logic [lbgc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lbgc_pkg::COLOR_W-1:0]   i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // Fields from bit 0: cell_index[3:0], cell_color[27:4], zero fill.
    input  logic [lbgc_pkg::TDATA_W-1:0]   s_axis_tdata,
    // Fields from bit 0: action.
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // Fields from bit 0: led_index[3:0], led_color[27:4], zero fill.
    output logic [lbgc_pkg::TDATA_W-1:0]   m_axis_tdata,
    output logic                          m_axis_tlast
);

    logic           w_push_valid;
    logic           w_push_ready;
    lbgc_pkg::t_cmd w_push_cmd;
    logic           w_pop_valid;
    logic           w_pop;
    lbgc_pkg::t_cmd w_pop_cmd;

    lbgc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_push_valid  (w_push_valid),
        .i_push_ready  (w_push_ready),
        .o_cmd         (w_push_cmd)
    );

    lbgc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_cmd        (w_push_cmd),
        .o_pop_valid  (w_pop_valid),
        .i_pop        (w_pop),
        .o_cmd        (w_pop_cmd)
    );

    lbgc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (w_pop_valid),
        .i_q_cmd     (w_pop_cmd),
        .o_q_pop     (w_pop),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tlast   (m_axis_tlast)
    );

endmodule

// ----- rtl/lbgc_div.sv -----
// Restoring divider for one 8-bit color difference, one quotient bit per cycle.
`timescale 1ns / 1ps

module lbgc_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [lbgc_pkg::CH_W-1:0] i_dividend,
    input  logic [lbgc_pkg::CH_W-1:0] i_divisor,
    output logic                     o_done,
    output logic [lbgc_pkg::CH_W-1:0] o_quotient
);

    logic                              r_busy;
    logic                              r_done;
    logic [lbgc_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [lbgc_pkg::CH_W-1:0]         r_rem;
    logic [lbgc_pkg::CH_W-1:0]         r_quo;
    logic [lbgc_pkg::CH_W:0]           n_trial;
    logic [lbgc_pkg::CH_W:0]           n_sub;
    logic                              n_fit;
    logic [lbgc_pkg::CH_W-1:0]         n_rem;

    always_comb begin
        n_trial = {r_rem, r_quo[lbgc_pkg::CH_W-1]};
        n_sub   = n_trial - {1'b0, i_divisor};
        n_fit   = (n_trial >= {1'b0, i_divisor});
        n_rem   = n_fit ? n_sub[lbgc_pkg::CH_W-1:0] : n_trial[lbgc_pkg::CH_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == lbgc_pkg::DIV_CNT_W'(lbgc_pkg::CH_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[lbgc_pkg::CH_W-2:0], n_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/lbgc_front.sv -----
// Input stage that takes requests, classifies them and drops writes to missing cells.
`timescale 1ns / 1ps

module lbgc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [lbgc_pkg::TDATA_W-1:0] s_axis_tdata,
    input  logic                        s_axis_tuser,
    output logic                        o_push_valid,
    input  logic                        i_push_ready,
    output lbgc_pkg::t_cmd              o_cmd
);

    logic                 r_valid;
    lbgc_pkg::t_cmd       r_cmd;
    lbgc_pkg::t_cmd       n_cmd;
    logic                 n_keep;
    logic                 n_accept;

    always_comb begin
        n_cmd.kind  = s_axis_tuser ? lbgc_pkg::CMD_WRITE : lbgc_pkg::CMD_TICK;
        n_cmd.idx   = s_axis_tdata[lbgc_pkg::IDX_W-1:0];
        n_cmd.color = s_axis_tdata[lbgc_pkg::IDX_W +: lbgc_pkg::COLOR_W];
        n_keep      = !(s_axis_tuser && (n_cmd.idx > lbgc_pkg::LAST_CELL));
        n_accept    = s_axis_tvalid && s_axis_tready;
    end

    assign s_axis_tready = !r_valid || i_push_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (n_accept) begin
            r_valid <= n_keep;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_push_valid = r_valid;
    assign o_cmd        = r_cmd;

endmodule

// ----- rtl/lbgc_queue.sv -----
// Short command queue between the input stage and the frame engine.
`timescale 1ns / 1ps

module lbgc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  lbgc_pkg::t_cmd i_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop,
    output lbgc_pkg::t_cmd o_cmd
);

    lbgc_pkg::t_cmd                 r_mem [lbgc_pkg::QUEUE_DEPTH];
    logic [lbgc_pkg::QPTR_W-1:0]    r_wr;
    logic [lbgc_pkg::QPTR_W-1:0]    r_rd;
    logic [lbgc_pkg::QCNT_W-1:0]    r_count;
    logic                           n_push;
    logic                           n_pop;

    assign o_push_ready = (r_count != lbgc_pkg::QCNT_W'(lbgc_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign n_push       = i_push_valid && o_push_ready;
    assign n_pop        = i_pop && o_pop_valid;
    assign o_cmd        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (n_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (n_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (n_push && !n_pop) begin
                r_count <= r_count + 1'b1;
            end else if (n_pop && !n_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ----- rtl/lbgc_back.sv -----
// Frame engine: base color store, tick counting, gradient division and cell output.
`timescale 1ns / 1ps

module lbgc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wen,
    input  logic [lbgc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lbgc_pkg::COLOR_W-1:0]   i_cfg_wdata,
    input  logic                          i_q_valid,
    input  lbgc_pkg::t_cmd                i_q_cmd,
    output logic                          o_q_pop,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [lbgc_pkg::TDATA_W-1:0]   o_m_tdata,
    output logic                          o_m_tlast
);

    localparam int CW = lbgc_pkg::CH_W;
    localparam int IW = lbgc_pkg::IDX_W;

    function automatic logic [CW-1:0] chan(input logic [lbgc_pkg::COLOR_W-1:0] c,
                                           input logic [1:0] sel);
        logic [CW-1:0] v;
        v = c[CW-1:0];
        if (sel == 2'd0) begin
            v = c[3*CW-1:2*CW];
        end else if (sel == 2'd1) begin
            v = c[2*CW-1:CW];
        end
        return v;
    endfunction

    lbgc_pkg::t_back_state              r_state;
    lbgc_pkg::t_back_state              n_state;
    logic [lbgc_pkg::COLOR_W-1:0]       r_accent;
    logic [lbgc_pkg::STEPS_W-1:0]       r_steps;
    logic [lbgc_pkg::PERIOD_W-1:0]      r_period;
    logic [lbgc_pkg::COLOR_W-1:0]       r_base [lbgc_pkg::BAR_CELLS];
    logic [IW-1:0]                      r_head;
    logic [lbgc_pkg::STEPS_W-1:0]       r_step;
    logic [lbgc_pkg::TICKS_W-1:0]       r_ticks;
    logic [lbgc_pkg::DSEL_W-1:0]        r_dsel;
    logic [CW-1:0]                      r_ofs [lbgc_pkg::NUM_DIV];
    logic [IW-1:0]                      r_cell;
    logic                               r_out_valid;
    logic [IW-1:0]                      r_out_idx;
    logic [lbgc_pkg::COLOR_W-1:0]       r_out_color;
    logic                               r_out_last;

    logic [IW-1:0]                      n_mid;
    logic [IW-1:0]                      n_tail;
    logic [IW-1:0]                      n_rd_addr;
    logic [lbgc_pkg::COLOR_W-1:0]       n_base_rd;
    logic                               n_head_side;
    logic [1:0]                         n_ch;
    logic [CW-1:0]                      n_a;
    logic [CW-1:0]                      n_b;
    logic                               n_neg;
    logic [CW-1:0]                      n_mag;
    logic [CW-1:0]                      n_grad;
    logic [2*CW-1:0]                    n_prod;
    logic [lbgc_pkg::TICKS_W-1:0]       n_ticks_inc;
    logic                               n_frame;
    logic                               n_div_start;
    logic                               n_div_done;
    logic [CW-1:0]                      n_quo;
    logic                               n_out_load;
    logic [lbgc_pkg::COLOR_W-1:0]       n_fade_head;
    logic [lbgc_pkg::COLOR_W-1:0]       n_fade_tail;
    logic [lbgc_pkg::COLOR_W-1:0]       n_color;

    always_comb begin
        n_mid  = (r_head == '0) ? lbgc_pkg::LAST_CELL : r_head - 1'b1;
        n_tail = (r_head < IW'(2)) ? r_head + IW'(lbgc_pkg::BAR_CELLS - 2)
                                   : r_head - IW'(2);
        n_head_side = (r_dsel < lbgc_pkg::DSEL_W'(3));
        if (r_state == lbgc_pkg::ST_EMIT) begin
            n_rd_addr = r_cell;
        end else begin
            n_rd_addr = n_head_side ? r_head : n_tail;
        end
        n_base_rd = r_base[n_rd_addr];
        n_ch = n_head_side ? r_dsel[1:0] : 2'(r_dsel - lbgc_pkg::DSEL_W'(3));
        if (n_head_side) begin
            n_a = chan(n_base_rd, n_ch);
            n_b = chan(r_accent, n_ch);
        end else begin
            n_a = chan(r_accent, n_ch);
            n_b = chan(n_base_rd, n_ch);
        end
        n_neg  = (n_b < n_a);
        n_mag  = n_neg ? n_a - n_b : n_b - n_a;
        if (r_steps == '0) begin
            n_grad = '0;
        end else begin
            n_grad = n_neg ? CW'(-n_quo) : n_quo;
        end
        n_prod = r_step * n_grad;

        n_ticks_inc = (r_ticks == lbgc_pkg::TICKS_MAX) ? r_ticks : r_ticks + 1'b1;
        n_frame     = (n_ticks_inc > {1'b0, r_period});

        n_fade_head = {chan(n_base_rd, 2'd0) + r_ofs[0],
                       chan(n_base_rd, 2'd1) + r_ofs[1],
                       chan(n_base_rd, 2'd2) + r_ofs[2]};
        n_fade_tail = {chan(r_accent, 2'd0) + r_ofs[3],
                       chan(r_accent, 2'd1) + r_ofs[4],
                       chan(r_accent, 2'd2) + r_ofs[5]};
        if (r_cell == r_head) begin
            n_color = n_fade_head;
        end else if (r_cell == n_mid) begin
            n_color = r_accent;
        end else if (r_cell == n_tail) begin
            n_color = n_fade_tail;
        end else begin
            n_color = n_base_rd;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_q_pop     = 1'b0;
        n_div_start = 1'b0;
        n_out_load  = 1'b0;
        unique case (r_state)
            lbgc_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_cmd.kind == lbgc_pkg::CMD_TICK && n_frame) begin
                        n_state = lbgc_pkg::ST_DSTART;
                    end
                end
            end
            lbgc_pkg::ST_DSTART: begin
                n_div_start = 1'b1;
                n_state     = lbgc_pkg::ST_DWAIT;
            end
            lbgc_pkg::ST_DWAIT: begin
                if (n_div_done) begin
                    if (r_dsel == lbgc_pkg::DSEL_W'(lbgc_pkg::NUM_DIV - 1)) begin
                        n_state = lbgc_pkg::ST_EMIT;
                    end else begin
                        n_state = lbgc_pkg::ST_DSTART;
                    end
                end
            end
            lbgc_pkg::ST_EMIT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_load = 1'b1;
                    if (r_cell == lbgc_pkg::LAST_CELL) begin
                        n_state = lbgc_pkg::ST_IDLE;
                    end
                end
            end
        endcase
    end

    lbgc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend (n_mag),
        .i_divisor  (r_steps),
        .o_done     (n_div_done),
        .o_quotient (n_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lbgc_pkg::ST_IDLE;
            r_accent    <= lbgc_pkg::ACCENT_RESET;
            r_steps     <= lbgc_pkg::STEPS_RESET;
            r_period    <= lbgc_pkg::PERIOD_RESET;
            r_head      <= '0;
            r_step      <= '0;
            r_ticks     <= '0;
            r_dsel      <= '0;
            r_cell      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < lbgc_pkg::BAR_CELLS; i++) begin
                r_base[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_wen) begin
                if (i_cfg_idx == lbgc_pkg::REG_ACCENT) begin
                    r_accent <= i_cfg_wdata;
                end else if (i_cfg_idx == lbgc_pkg::REG_STEPS) begin
                    r_steps <= i_cfg_wdata[lbgc_pkg::STEPS_W-1:0];
                end else if (i_cfg_idx == lbgc_pkg::REG_PERIOD) begin
                    r_period <= i_cfg_wdata[lbgc_pkg::PERIOD_W-1:0];
                end
            end
            if (o_q_pop) begin
                if (i_q_cmd.kind == lbgc_pkg::CMD_WRITE) begin
                    r_base[i_q_cmd.idx] <= i_q_cmd.color;
                end else begin
                    r_ticks <= n_frame ? '0 : n_ticks_inc;
                    r_dsel  <= '0;
                end
            end
            if (r_state == lbgc_pkg::ST_DWAIT && n_div_done) begin
                r_dsel <= r_dsel + 1'b1;
            end
            if (n_out_load) begin
                r_out_valid <= 1'b1;
                if (r_cell == lbgc_pkg::LAST_CELL) begin
                    r_cell <= '0;
                    if (r_step == r_steps) begin
                        r_step <= '0;
                        r_head <= (r_head == lbgc_pkg::LAST_CELL) ? '0 : r_head + 1'b1;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end else begin
                    r_cell <= r_cell + 1'b1;
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lbgc_pkg::ST_DWAIT && n_div_done) begin
            r_ofs[r_dsel] <= n_prod[CW-1:0];
        end
        if (n_out_load) begin
            r_out_idx   <= r_cell;
            r_out_color <= n_color;
            r_out_last  <= (r_cell == lbgc_pkg::LAST_CELL);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(lbgc_pkg::TDATA_W - IW - lbgc_pkg::COLOR_W){1'b0}},
                         r_out_color, r_out_idx};
    assign o_m_tlast  = r_out_last;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the LED bar gradient chaser with its own frame predictor.
`timescale 1ns / 1ps

module tb_top;
    import lbgc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 150;
    localparam int MAX_REPORTS   = 40;
    localparam int FILL_W        = TDATA_W - IDX_W - COLOR_W;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [COLOR_W-1:0] color;
        logic               last;
    } cell_result_t;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_wen     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [COLOR_W-1:0]   i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic                 m_axis_tlast;

    led_bar_gradient_chaser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Predicted state of the bar.
    logic [COLOR_W-1:0]  accent_q = ACCENT_RESET;
    logic [STEPS_W-1:0]  steps_q  = STEPS_RESET;
    logic [PERIOD_W-1:0] period_q = PERIOD_RESET;
    logic [COLOR_W-1:0]  base_q [BAR_CELLS] = '{default: '0};
    logic [IDX_W-1:0]    head_q   = '0;
    logic [STEPS_W-1:0]  step_q   = '0;
    logic [TICKS_W-1:0]  ticks_q  = '0;

    cell_result_t cell_color_q[$];
    int  mismatch_count = 0;
    bit  gaps_on        = 1'b1;
    int  burst_left     = 0;
    int  rx_cycle       = 0;
    int  rx_mode        = 0;
    int  rx_hold        = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #48_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [CH_W-1:0] fade_channel_value(logic [CH_W-1:0] from_ch,
            logic [CH_W-1:0] to_ch, logic [STEPS_W-1:0] k, logic [STEPS_W-1:0] n_steps);
        int diff;
        int grad;
        int val;
        diff = int'(to_ch) - int'(from_ch);
        grad = (n_steps != 0) ? diff / int'(n_steps) : 0;
        val  = int'(from_ch) + int'(k) * grad;
        return val[CH_W-1:0];
    endfunction

    function automatic logic [COLOR_W-1:0] fade_color(logic [COLOR_W-1:0] from_c,
            logic [COLOR_W-1:0] to_c, logic [STEPS_W-1:0] k, logic [STEPS_W-1:0] n_steps);
        return {fade_channel_value(from_c[23:16], to_c[23:16], k, n_steps),
                fade_channel_value(from_c[15:8], to_c[15:8], k, n_steps),
                fade_channel_value(from_c[7:0], to_c[7:0], k, n_steps)};
    endfunction

    // Applies one accepted request to the predicted state and queues any frame it causes.
    task automatic advance_chaser(t_cmd_kind kind, logic [IDX_W-1:0] idx,
            logic [COLOR_W-1:0] color);
        logic [COLOR_W-1:0] frame [BAR_CELLS];
        int head;
        int mid;
        int tail;
        cell_result_t cell_rec;
        if (kind == CMD_WRITE) begin
            if (idx < BAR_CELLS)
                base_q[idx] = color;
            return;
        end
        if (ticks_q != TICKS_MAX)
            ticks_q = ticks_q + 1'b1;
        if (ticks_q <= TICKS_W'(period_q))
            return;
        ticks_q = '0;
        head = int'(head_q) % BAR_CELLS;
        mid  = (head + BAR_CELLS - 1) % BAR_CELLS;
        tail = (head + BAR_CELLS - 2) % BAR_CELLS;
        frame = base_q;
        frame[head] = fade_color(base_q[head], accent_q, step_q, steps_q);
        frame[mid]  = accent_q;
        frame[tail] = fade_color(accent_q, base_q[tail], step_q, steps_q);
        for (int c = 0; c < BAR_CELLS; c++) begin
            cell_rec.idx   = IDX_W'(c);
            cell_rec.color = frame[c];
            cell_rec.last  = (c == BAR_CELLS - 1);
            cell_color_q.push_back(cell_rec);
        end
        if (step_q == steps_q) begin
            step_q = '0;
            head_q = (head == BAR_CELLS - 1) ? '0 : IDX_W'(head + 1);
        end else begin
            step_q = step_q + 1'b1;
        end
    endtask

    task automatic send_request(t_cmd_kind kind, logic [IDX_W-1:0] idx,
            logic [COLOR_W-1:0] color);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{FILL_W{1'b0}}, color, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        advance_chaser(kind, idx, color);
        if (gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 48)
                                                         : $urandom_range(0, 6);
                gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 5);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_tick();
        send_request(CMD_TICK, IDX_W'($urandom), COLOR_W'($urandom));
    endtask

    // Holds the sender off until every predicted cell has arrived and the block is quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (cell_color_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] value);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        case (idx)
            REG_ACCENT: accent_q = value;
            REG_STEPS:  steps_q  = value[STEPS_W-1:0];
            REG_PERIOD: period_q = value[PERIOD_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic test_reset_frame();
        repeat (int'(PERIOD_RESET) + 1) send_tick();
    endtask

    task automatic test_base_writes();
        logic [COLOR_W-1:0] palette [BAR_CELLS];
        palette = '{24'h000000, 24'hFFFFFF, 24'hFF00FF, 24'h00FF00, 24'h0F0F0F,
                    24'hF0F0F0, 24'h800080, 24'h7F7F7F, 24'hA5A55A};
        for (int c = 0; c < BAR_CELLS; c++)
            send_request(CMD_WRITE, IDX_W'(c), palette[c]);
        send_request(CMD_WRITE, IDX_W'(BAR_CELLS), 24'hFFFFFF);
        send_request(CMD_WRITE, {IDX_W{1'b1}}, 24'h00FF00);
        settle();
        write_register(REG_ACCENT, 24'h00FF00);
        write_register(REG_STEPS, 24'd3);
        write_register(REG_PERIOD, 24'd0);
        repeat (8) send_tick();
    endtask

    task automatic test_zero_steps();
        settle();
        write_register(REG_ACCENT, 24'h5AA5C3);
        write_register(REG_STEPS, 24'd0);
        repeat (10) send_tick();
    endtask

    task automatic test_register_extremes();
        settle();
        write_register(REG_ACCENT, 24'hFFFFFF);
        write_register(REG_STEPS, 24'hFFFFFF);
        repeat (4) send_tick();
        settle();
        write_register(REG_UNUSED, 24'hFFFFFF);
        write_register(REG_ACCENT, 24'h000000);
        write_register(REG_STEPS, 24'h000001);
        repeat (4) send_tick();
        settle();
        write_register(REG_PERIOD, 24'h00FFFF);
        repeat (4) send_tick();
        settle();
        write_register(REG_PERIOD, 24'd1);
        repeat (4) send_tick();
    endtask

    task automatic test_step_wraparound();
        logic [IDX_W-1:0] start_head;
        settle();
        write_register(REG_STEPS, 24'd200);
        write_register(REG_PERIOD, 24'd0);
        while (step_q < 2) send_tick();
        settle();
        // The step count now sits above the new limit and must wrap before the head moves.
        write_register(REG_STEPS, 24'd1);
        start_head = head_q;
        gaps_on = 1'b0;
        while (head_q == start_head) send_tick();
        gaps_on = 1'b1;
        repeat (3) send_tick();
    endtask

    task automatic test_random_traffic();
        int roll;
        logic [COLOR_W-1:0] steps_word;
        logic [COLOR_W-1:0] period_word;
        for (int phase = 0; phase < 3; phase++) begin
            settle();
            steps_word  = COLOR_W'($urandom);
            period_word = COLOR_W'($urandom);
            roll = $urandom_range(0, 9);
            if (roll < 6)
                steps_word[STEPS_W-1:0] = STEPS_W'($urandom_range(1, 6));
            else if (roll == 6)
                steps_word[STEPS_W-1:0] = '0;
            else if (roll == 7)
                steps_word[STEPS_W-1:0] = '1;
            roll = $urandom_range(0, 9);
            if (roll < 8)
                period_word[PERIOD_W-1:0] = PERIOD_W'($urandom_range(0, 3));
            else
                period_word[PERIOD_W-1:0] = PERIOD_W'($urandom_range(4, 30));
            write_register(REG_ACCENT, COLOR_W'($urandom));
            write_register(REG_STEPS, steps_word);
            write_register(REG_PERIOD, period_word);
            for (int n = 0; n < 12; n++) begin
                if (phase == 1 && n == 6)
                    settle();
                if ($urandom_range(0, 99) < 65)
                    send_tick();
                else if ($urandom_range(0, 7) == 0)
                    send_request(CMD_WRITE, IDX_W'($urandom_range(BAR_CELLS, 15)),
                                 COLOR_W'($urandom));
                else
                    send_request(CMD_WRITE, IDX_W'($urandom_range(0, BAR_CELLS - 1)),
                                 COLOR_W'($urandom));
            end
        end
    endtask

    // Receiver backpressure in one of four modes that is redrawn at random.
    always @(posedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 256 == 0)
            rx_mode = $urandom_range(0, 3);
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: begin
                    m_axis_tready <= 1'b1;
                end
                1: begin
                    m_axis_tready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_axis_tready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    if ($urandom_range(0, 11) == 0) begin
                        rx_hold = $urandom_range(1, 24);
                        m_axis_tready <= 1'b0;
                    end else begin
                        m_axis_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin : check_cells
        cell_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (cell_color_q.size() == 0) begin
                report_mismatch("unexpected cell", m_axis_tdata, '0);
            end else begin
                want = cell_color_q.pop_front();
                if (m_axis_tdata[IDX_W-1:0] !== want.idx)
                    report_mismatch("led_index", 32'(m_axis_tdata[IDX_W-1:0]),
                                    32'(want.idx));
                if (m_axis_tdata[IDX_W +: COLOR_W] !== want.color)
                    report_mismatch("led_color", 32'(m_axis_tdata[IDX_W +: COLOR_W]),
                                    32'(want.color));
                if (m_axis_tlast !== want.last)
                    report_mismatch("last_cell", 32'(m_axis_tlast), 32'(want.last));
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_frame();
        test_base_writes();
        test_zero_steps();
        test_register_extremes();
        test_step_wraparound();
        test_random_traffic();
        settle();
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
